>>> rtl/core/aas_pkg.sv
`default_nettype none
package aas_pkg;

    // Fixed formats of the fields.
    localparam int EW = 32;       // energy width, signed Q16.16
    localparam int FB = 16;       // fraction bits
    localparam int TW = 32;       // temperature and k width
    localparam int DW = 24;       // damping factor width, Q8.16
    localparam int RW = 16;       // round counter width
    localparam int QW = 20;       // quotient bits of dE / kT
    localparam int YW = 21;       // x * log2(e) in Q5.16
    localparam int AW = 33;       // power accumulator, Q1.32
    localparam int CW = 6;        // iteration counter width

    localparam logic [24:0] LOG2E_Q24 = 25'd24204406;

    // Last iteration indexes of the shared divider and the power unit.
    localparam logic [CW-1:0] EXP_DIV_LAST  = CW'(QW - 1);
    localparam logic [CW-1:0] DAMP_DIV_LAST = CW'(TW - 1);
    localparam logic [CW-1:0] POW_LAST      = CW'(FB - 1);

    // Configuration register indexes.
    localparam logic [2:0] CFG_K       = 3'd0;
    localparam logic [2:0] CFG_T_START = 3'd1;
    localparam logic [2:0] CFG_T_MIN   = 3'd2;
    localparam logic [2:0] CFG_T_RST   = 3'd3;
    localparam logic [2:0] CFG_DAMP    = 3'd4;
    localparam logic [2:0] CFG_ITERS   = 3'd5;

    // Request kinds.
    localparam logic REQ_START = 1'b0;

    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_EVAL  = 13'b0000000000010,
        S_KT    = 13'b0000000000100,
        S_KTCHK = 13'b0000000001000,
        S_DIV   = 13'b0000000010000,
        S_LOG   = 13'b0000000100000,
        S_POW   = 13'b0000001000000,
        S_CMP   = 13'b0000010000000,
        S_ROUND = 13'b0000100000000,
        S_DDIV  = 13'b0001000000000,
        S_DFIN  = 13'b0010000000000,
        S_CHK   = 13'b0100000000000,
        S_OUT   = 13'b1000000000000
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic          capture;
        logic          eval;
        logic          kt_mul;
        logic          kt_chk;
        logic          div_step;
        logic          log_mul;
        logic          pow_step;
        logic [3:0]    pow_idx;
        logic          cmp;
        logic          round;
        logic          damp_fin;
        logic          chk;
        logic          out_load;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic uphill;     // active candidate above both best and current
        logic downhill;   // active candidate taken without exp
        logic exp_go;     // exp is not trivially zero
        logic wrap;       // this round ends a temperature step
        logic damp_div;   // damping needs a real division
    } t_sts;

    // round(2^32 * 2^-(2^-(i+1))) for the bits of the fractional exponent.
    function automatic logic [31:0] pow2_neg(input logic [3:0] i);
        logic [31:0] c;
        case (i)
            4'd0:  c = 32'd3037000500;
            4'd1:  c = 32'd3611622603;
            4'd2:  c = 32'd3938502376;
            4'd3:  c = 32'd4112874773;
            4'd4:  c = 32'd4202935003;
            4'd5:  c = 32'd4248701965;
            4'd6:  c = 32'd4271771996;
            4'd7:  c = 32'd4283353945;
            4'd8:  c = 32'd4289156690;
            4'd9:  c = 32'd4292061010;
            4'd10: c = 32'd4293513907;
            4'd11: c = 32'd4294240540;
            4'd12: c = 32'd4294603903;
            4'd13: c = 32'd4294785595;
            4'd14: c = 32'd4294876445;
            default: c = 32'd4294921870;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

>>> rtl/core/annealing_acceptance_scheduler.sv
`default_nettype none
// Metropolis acceptance core for simulated annealing. A start item (tuser 0)
// loads its energy as current and best and begins a run at the start
// temperature; a candidate item (tuser 1) is accepted when it is not above
// current, or when its random fraction is below exp(-dE/(k*T)). One item is
// processed at a time and gives one result item. Starts and ignored
// candidates skip the round update; an uphill candidate first passes the kT
// multiply and, unless exp is trivially zero, the 20-step restoring divider,
// the log2(e) multiply and the 16-step power series. The last candidate of a
// temperature step adds the minimum and restart check, after a division of
// the temperature by the damping factor in 32 steps on the same divider
// where needed. A new item is taken while the previous result still waits at
// the output register; the next result is held back until that one is taken.
module annealing_acceptance_scheduler (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_cfg_we,
    input  wire logic [2:0]   i_cfg_idx,
    input  wire logic [31:0]  i_cfg_data,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // [31:0] candidate_energy, [47:32] rand_fraction
    input  wire logic [47:0]  s_axis_tdata,
    // [0] req_type
    input  wire logic         s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // [31:0] current_energy_out, [63:32] best_energy_out, [95:64] temperature_out
    output logic [95:0]       m_axis_tdata,
    // [0] take_new_as_current, [1] take_new_as_best, [2] restored_best, [3] finished
    output logic [3:0]        m_axis_tuser
);
    import aas_pkg::*;

    t_cmd cmd;
    t_sts sts;

    aas_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    aas_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (s_axis_tuser),
        .i_energy   (s_axis_tdata[31:0]),
        .i_rnd      (s_axis_tdata[47:32]),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_flags    (m_axis_tuser),
        .o_data     (m_axis_tdata)
    );

endmodule
`default_nettype wire

>>> rtl/core/aas_dp.sv
`default_nettype none
module aas_dp (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [2:0]           i_cfg_idx,
    input  wire logic [31:0]          i_cfg_data,
    input  wire logic                 i_req,
    input  wire logic [31:0]          i_energy,
    input  wire logic [15:0]          i_rnd,
    input  wire aas_pkg::t_cmd        i_cmd,
    output aas_pkg::t_sts             o_sts,
    output logic [3:0]                o_flags,
    output logic [95:0]               o_data
);
    import aas_pkg::*;

    // Configuration registers.
    logic [TW-1:0] r_k, r_t_start, r_t_min, r_t_rst;
    logic [DW-1:0] r_damp;
    logic [RW-1:0] r_iters;

    // Item and run state.
    logic          r_req;
    logic [EW-1:0] r_e, r_cur, r_best;
    logic [15:0]   r_rnd;
    logic [TW-1:0] r_temp;
    logic [RW-1:0] r_round;
    logic          r_armed, r_fin;
    logic          r_tc, r_tb, r_rs;

    // Arithmetic registers.
    logic [63:0]   r_prod;
    logic [31:0]   r_rem, r_dvd, r_quo, r_dvs;
    logic [YW-1:0] r_y;
    logic [AW-1:0] r_acc;

    // Output register.
    logic [3:0]    r_oflags;
    logic [95:0]   r_odata;

    logic [47:0]   kt_wide;
    logic [31:0]   kt;
    logic [32:0]   de_full;
    logic [31:0]   de;
    logic [32:0]   div_t;
    logic          div_ge;
    logic [RW-1:0] round_inc;
    logic [45:0]   log_prod;
    logic [64:0]   pow_prod;
    logic [5:0]    exp_sh;
    logic [AW-1:0] exp_val;
    logic          e_le_best, e_le_cur;

    // Scaled temperature with saturation, and the energy step.
    assign kt_wide   = r_prod[63:16];
    assign kt        = (|kt_wide[47:32]) ? 32'hFFFF_FFFF : kt_wide[31:0];
    assign de_full   = {r_e[EW-1], r_e} - {r_cur[EW-1], r_cur};
    assign de        = de_full[31:0];
    assign e_le_best = $signed(r_e) <= $signed(r_best);
    assign e_le_cur  = $signed(r_e) <= $signed(r_cur);

    // One restoring division step of the shared divider.
    assign div_t  = {r_rem, r_dvd[31]};
    assign div_ge = div_t >= {1'b0, r_dvs};

    assign round_inc = r_round + RW'(1);
    assign log_prod  = r_quo[QW-1:0] * LOG2E_Q24;
    assign pow_prod  = r_acc * pow2_neg(i_cmd.pow_idx);
    assign exp_sh    = 6'd16 + {1'b0, r_y[YW-1:FB]};
    assign exp_val   = r_acc >> exp_sh;

    // Status toward the controller.
    always_comb begin
        o_sts.uphill   = r_req && !r_fin && !e_le_best && !e_le_cur;
        o_sts.downhill = r_req && !r_fin && (e_le_best || e_le_cur);
        o_sts.exp_go   = (kt != 32'd0) && ({4'd0, de} < {kt, 4'd0});
        o_sts.wrap     = round_inc >= r_iters;
        o_sts.damp_div = (r_damp != DW'(0)) && ({8'd0, r_temp[31:16]} < r_damp);
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k       <= 32'd65536;
            r_t_start <= 32'd655360;
            r_t_min   <= 32'd66;
            r_t_rst   <= 32'd0;
            r_damp    <= 24'd68813;
            r_iters   <= 16'd100;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_K:       r_k       <= i_cfg_data;
                CFG_T_START: r_t_start <= i_cfg_data;
                CFG_T_MIN:   r_t_min   <= i_cfg_data;
                CFG_T_RST:   r_t_rst   <= i_cfg_data;
                CFG_DAMP:    r_damp    <= i_cfg_data[DW-1:0];
                CFG_ITERS:   r_iters   <= i_cfg_data[RW-1:0];
                default: begin
                end
            endcase
        end
    end

    // Run state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur   <= '0;
            r_best  <= '0;
            r_temp  <= '0;
            r_round <= '0;
            r_armed <= 1'b1;
            r_fin   <= 1'b1;
            r_tc    <= 1'b0;
            r_tb    <= 1'b0;
            r_rs    <= 1'b0;
        end else begin
            if (i_cmd.eval) begin
                r_rs <= 1'b0;
                r_tc <= 1'b0;
                r_tb <= 1'b0;
                if (r_req == REQ_START) begin
                    r_cur   <= r_e;
                    r_best  <= r_e;
                    r_temp  <= r_t_start;
                    r_round <= '0;
                    r_armed <= 1'b1;
                    r_fin   <= 1'b0;
                    r_tc    <= 1'b1;
                    r_tb    <= 1'b1;
                end else if (!r_fin) begin
                    if (e_le_best) begin
                        r_best <= r_e;
                        r_cur  <= r_e;
                        r_tc   <= 1'b1;
                        r_tb   <= 1'b1;
                    end else if (e_le_cur) begin
                        r_cur <= r_e;
                        r_tc  <= 1'b1;
                    end
                end
            end
            // Metropolis test against the computed exp.
            if (i_cmd.cmp && ({17'd0, r_rnd} < exp_val)) begin
                r_cur <= r_e;
                r_tc  <= 1'b1;
            end
            // Round bookkeeping; overflowing or zero damping saturates.
            if (i_cmd.round) begin
                r_round <= o_sts.wrap ? '0 : round_inc;
                if (o_sts.wrap && !o_sts.damp_div) begin
                    r_temp <= 32'hFFFF_FFFF;
                end
            end
            if (i_cmd.damp_fin) begin
                r_temp <= r_quo;
            end
            // Finish wins over a restart.
            if (i_cmd.chk) begin
                if (r_temp < r_t_min) begin
                    r_fin <= 1'b1;
                end else if (r_armed && (r_temp < r_t_rst)) begin
                    r_cur   <= r_best;
                    r_armed <= 1'b0;
                    r_rs    <= 1'b1;
                end
            end
        end
    end

    // Item capture and the arithmetic units.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req <= i_req;
            r_e   <= i_energy;
            r_rnd <= i_rnd;
        end
        if (i_cmd.kt_mul) begin
            r_prod <= r_k * r_temp;
        end
        // Divider loads: dE * 2^16 / kT, or T * 2^16 / damping.
        if (i_cmd.kt_chk) begin
            r_rem <= {4'd0, de[31:4]};
            r_dvd <= {de[3:0], 28'd0};
            r_dvs <= kt;
            r_quo <= '0;
        end else if (i_cmd.round) begin
            r_rem <= {16'd0, r_temp[31:16]};
            r_dvd <= {r_temp[15:0], 16'd0};
            r_dvs <= {8'd0, r_damp};
            r_quo <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= div_ge ? 32'(div_t - {1'b0, r_dvs}) : div_t[31:0];
            r_dvd <= {r_dvd[30:0], 1'b0};
            r_quo <= {r_quo[30:0], div_ge};
        end
        if (i_cmd.log_mul) begin
            r_y   <= log_prod[24 +: YW];
            r_acc <= {1'b1, 32'd0};
        end else if (i_cmd.pow_step && r_y[FB - 1 - int'(i_cmd.pow_idx)]) begin
            r_acc <= pow_prod[32 +: AW];
        end
        if (i_cmd.out_load) begin
            r_oflags <= {r_fin, r_rs, r_tb, r_tc};
            r_odata  <= {r_temp, r_best, r_cur};
        end
    end

    assign o_flags = r_oflags;
    assign o_data  = r_odata;

endmodule
`default_nettype wire

>>> rtl/core/aas_ctrl.sv
`default_nettype none
module aas_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  wire logic            i_out_ready,
    input  wire aas_pkg::t_sts   i_sts,
    output aas_pkg::t_cmd        o_cmd
);
    import aas_pkg::*;

    t_state         r_state, n_state;
    logic [CW-1:0]  r_cnt, n_cnt;
    logic           r_ovalid, n_ovalid;
    logic           out_free;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;
    assign out_free    = !r_ovalid || i_out_ready;

    // Sequencer for one item.
    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_ovalid = r_ovalid && !i_out_ready;
        o_cmd    = '0;
        o_cmd.pow_idx = r_cnt[3:0];
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                if (i_sts.uphill) begin
                    n_state = S_KT;
                end else if (i_sts.downhill) begin
                    n_state = S_ROUND;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_KT: begin
                o_cmd.kt_mul = 1'b1;
                n_state = S_KTCHK;
            end
            S_KTCHK: begin
                o_cmd.kt_chk = 1'b1;
                n_cnt = EXP_DIV_LAST;
                n_state = i_sts.exp_go ? S_DIV : S_ROUND;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt = r_cnt - CW'(1);
                if (r_cnt == '0) begin
                    n_state = S_LOG;
                end
            end
            S_LOG: begin
                o_cmd.log_mul = 1'b1;
                n_cnt = '0;
                n_state = S_POW;
            end
            S_POW: begin
                o_cmd.pow_step = 1'b1;
                n_cnt = r_cnt + CW'(1);
                if (r_cnt == POW_LAST) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                o_cmd.cmp = 1'b1;
                n_state = S_ROUND;
            end
            S_ROUND: begin
                o_cmd.round = 1'b1;
                n_cnt = DAMP_DIV_LAST;
                if (!i_sts.wrap) begin
                    n_state = S_OUT;
                end else if (i_sts.damp_div) begin
                    n_state = S_DDIV;
                end else begin
                    n_state = S_CHK;
                end
            end
            S_DDIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt = r_cnt - CW'(1);
                if (r_cnt == '0) begin
                    n_state = S_DFIN;
                end
            end
            S_DFIN: begin
                o_cmd.damp_fin = 1'b1;
                n_state = S_CHK;
            end
            S_CHK: begin
                o_cmd.chk = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_ovalid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_ovalid <= n_ovalid;
        end
    end

`ifndef SYNTH
    a_onehot_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state)) else $error("state register is not one-hot");

    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_cnt <= EXP_DIV_LAST))
        else $error("exp division ran past its quotient width");

    a_exp_skip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_KTCHK && !i_sts.exp_go) |=> (r_state == S_ROUND))
        else $error("zero exp did not skip to the round update");

    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && out_free) |=> (r_ovalid && r_state == S_IDLE))
        else $error("result was not presented after the output load");
`endif

endmodule
`default_nettype wire

>>> tb/sv/tb.sv
`timescale 1ns / 100ps
`default_nettype none
module tb;
    import aas_pkg::*;

    // One result item of the block.
    typedef struct packed {
        logic [31:0] temp;
        logic [31:0] best;
        logic [31:0] cur;
        logic        fin;
        logic        restored;
        logic        take_best;
        logic        take_cur;
    } t_outcome;

    // Scoreboard: tracks the annealing state and the queue of predicted outcomes.
    class anneal_scoreboard;
        logic [31:0] k_reg, t_start, t_min, t_rst;
        logic [23:0] damp_reg;
        logic [15:0] iters;
        logic signed [31:0] cur_e, best_e;
        logic [31:0] temp;
        logic [15:0] rounds;
        bit armed, done;
        t_outcome pending[$];
        int mismatches, checked;

        function void reset_state();
            k_reg = 32'd65536; t_start = 32'd655360; t_min = 32'd66; t_rst = 0;
            damp_reg = 24'd68813; iters = 16'd100;
            cur_e = 0; best_e = 0; temp = 0; rounds = 0; armed = 1; done = 1;
            mismatches = 0; checked = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] val);
            case (idx)
                CFG_K:       k_reg = val;
                CFG_T_START: t_start = val;
                CFG_T_MIN:   t_min = val;
                CFG_T_RST:   t_rst = val;
                CFG_DAMP:    damp_reg = val[23:0];
                CFG_ITERS:   iters = val[15:0];
                default: ;
            endcase
        endfunction

        // Acceptance probability exp(-de/kt) in Q1.16.
        function logic [63:0] boltz_factor(logic [63:0] de, logic [63:0] kt);
            logic [63:0] q, y, f, acc, sh;
            logic [31:0] c;
            if (kt == 0 || de >= kt * 16) return 0;
            q = (de << 16) / kt;
            y = (q * 64'd24204406) >> 24;
            f = y & 64'hFFFF;
            acc = 64'h1_0000_0000;
            for (int i = 0; i < 16; i++) begin
                if (f[15-i]) begin
                    c = pow2_const(i);
                    acc = (acc * c) >> 32;
                end
            end
            sh = 16 + (y >> 16);
            if (sh >= 64) return 0;
            return acc >> sh;
        endfunction

        function logic [31:0] pow2_const(int i);
            logic [31:0] tbl[16] = '{32'd3037000500, 32'd3611622603, 32'd3938502376,
                32'd4112874773, 32'd4202935003, 32'd4248701965, 32'd4271771996,
                32'd4283353945, 32'd4289156690, 32'd4292061010, 32'd4293513907,
                32'd4294240540, 32'd4294603903, 32'd4294785595, 32'd4294876445,
                32'd4294921870};
            return tbl[i];
        endfunction

        // Notes an accepted input item and predicts its outcome.
        function void note_input(logic req, logic signed [31:0] e, logic [15:0] rnd);
            t_outcome o;
            logic [63:0] kt, de, d;
            o = '0;
            if (req == REQ_START) begin
                cur_e = e; best_e = e; temp = t_start; rounds = 0;
                armed = 1; done = 0; o.take_cur = 1; o.take_best = 1;
            end else if (!done) begin
                if (e <= best_e) begin
                    best_e = e; cur_e = e; o.take_cur = 1; o.take_best = 1;
                end else if (e <= cur_e) begin
                    cur_e = e; o.take_cur = 1;
                end else begin
                    de = 64'(longint'(e) - longint'(cur_e));
                    kt = (64'(k_reg) * 64'(temp)) >> 16;
                    if (kt > 64'hFFFF_FFFF) kt = 64'hFFFF_FFFF;
                    if (64'(rnd) < boltz_factor(de, kt)) begin
                        cur_e = e; o.take_cur = 1;
                    end
                end
                rounds = rounds + 1;
                if (rounds >= iters) begin
                    rounds = 0;
                    if (damp_reg == 0) temp = 32'hFFFF_FFFF;
                    else begin
                        d = (64'(temp) << 16) / 64'(damp_reg);
                        temp = (d > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : d[31:0];
                    end
                    if (temp < t_min) done = 1;
                    else if (armed && temp < t_rst) begin
                        cur_e = best_e; armed = 0; o.restored = 1;
                    end
                end
            end
            o.fin = done; o.cur = cur_e; o.best = best_e; o.temp = temp;
            pending.push_back(o);
        endfunction

        // Compares one result item with the oldest prediction.
        function void check_result(t_outcome got);
            t_outcome exp_o;
            checked++;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", got);
                return;
            end
            exp_o = pending.pop_front();
            if (got !== exp_o) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"result %0d: expected cur=%h best=%h T=%h flags=%b%b%b%b,",
                              " got cur=%h best=%h T=%h flags=%b%b%b%b"},
                        checked, exp_o.cur, exp_o.best, exp_o.temp, exp_o.fin,
                        exp_o.restored, exp_o.take_best, exp_o.take_cur, got.cur,
                        got.best, got.temp, got.fin, got.restored, got.take_best,
                        got.take_cur);
            end
        endfunction
    endclass

    logic i_clk = 0, i_rst_n = 0;
    logic i_cfg_we = 0;
    logic [2:0] i_cfg_idx = 0;
    logic [31:0] i_cfg_data = 0;
    logic s_axis_tvalid = 0, s_axis_tuser = 0, m_axis_tready = 0;
    logic [47:0] s_axis_tdata = 0;
    logic s_axis_tready, m_axis_tvalid;
    logic [95:0] m_axis_tdata;
    logic [3:0] m_axis_tuser;

    anneal_scoreboard sb;
    longint cycles = 0;
    int stall_mode = 0;
    int items_sent = 0;

    annealing_acceptance_scheduler dut (.*);

    always #2 i_clk = ~i_clk;

    // Receiver: checks accepted results and drives ready in one of four patterns picked at random.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result({m_axis_tdata[95:64], m_axis_tdata[63:32], m_axis_tdata[31:0],
                             m_axis_tuser[3], m_axis_tuser[2], m_axis_tuser[1],
                             m_axis_tuser[0]});
        case (stall_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= ($urandom_range(0, 3) != 0);
            2: m_axis_tready <= ($urandom_range(0, 3) == 0);
            default: m_axis_tready <= cycles[3];
        endcase
        if (cycles % 1500 == 0) stall_mode <= $urandom_range(0, 3);
        if (cycles > 3000000) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Sends one item and holds it until the block takes it.
    task automatic send_item(logic req, logic [31:0] e, logic [15:0] rnd);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= req;
        s_axis_tdata <= {rnd, e};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_input(req, e, rnd);
        items_sent++;
    endtask

    task automatic idle_gap(int n);
        s_axis_tvalid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // Waits for all predictions to drain, then lets the datapath settle.
    task automatic drain();
        idle_gap(1);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    // One register write; the write enable is then dropped again before the task returns.
    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        i_cfg_we <= 1'b1; i_cfg_idx <= idx; i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.write_reg(idx, val);
        @(posedge i_clk);
    endtask

    // Candidate near the current energy, below the best energy or at random, so that uphill moves stay likely.
    function automatic logic [31:0] near_energy();
        int sp;
        sp = $urandom_range(0, 3);
        case (sp)
            0: return sb.cur_e + $signed($urandom_range(0, 32'h4_0000)) - 32'h1_0000;
            1: return sb.cur_e + $signed($urandom_range(0, 32'h40_0000));
            2: return sb.best_e - $signed($urandom_range(0, 32'h2_0000));
            default: return $urandom;
        endcase
    endfunction

    // One annealing run: a start followed by candidates sent in bursts, with some further starts among them.
    task automatic run_phase(int count);
        int burst;
        send_item(REQ_START, $urandom, 16'($urandom));
        while (count > 0) begin
            burst = $urandom_range(1, 12);
            while (burst > 0 && count > 0) begin
                if ($urandom_range(0, 30) == 0)
                    send_item(REQ_START, $urandom, 16'($urandom));
                else send_item(1'b1, near_energy(), 16'($urandom));
                burst--; count--;
            end
            if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 20));
        end
    endtask

    initial begin
        sb = new();
        sb.reset_state();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: candidate while idle, extremes and the special cases.
        send_item(1'b1, 32'h7FFF_FFFF, 16'hFFFF);
        send_item(REQ_START, 32'h8000_0000, 16'h0000);
        send_item(1'b1, 32'h7FFF_FFFF, 16'h0000);
        send_item(1'b1, 32'h8000_0000, 16'hFFFF);
        send_item(REQ_START, 32'h0000_0000, 16'hFFFF);
        send_item(1'b1, 32'h0000_8000, 16'h0000);
        send_item(1'b1, 32'h0000_8000, 16'hFFFF);
        send_item(1'b1, 32'hFFFF_0000, 16'h1234);
        send_item(1'b1, 32'h7FFF_FFFF, 16'h0000);
        drain();
        // Zero iteration count, fast damping, restart level: quick finish.
        write_reg(CFG_ITERS, 32'd0);
        write_reg(CFG_DAMP, 32'hFF_FFFF);
        write_reg(CFG_T_RST, 32'h0001_0000);
        write_reg(CFG_T_MIN, 32'd1);
        write_reg(CFG_T_START, 32'h0010_0000);
        send_item(REQ_START, 32'h0001_0000, 16'h0);
        for (int i = 0; i < 6; i++) send_item(1'b1, 32'h0002_0000 + i, 16'h0);
        drain();
        // Zero k, zero damping and zero minimum; then full-scale k and start temperature with damping at one.
        write_reg(CFG_K, 32'd0);
        write_reg(CFG_DAMP, 32'd0);
        write_reg(CFG_T_MIN, 32'd0);
        write_reg(CFG_ITERS, 32'd2);
        send_item(REQ_START, 32'd5, 16'h0);
        for (int i = 0; i < 4; i++) send_item(1'b1, 32'd9, 16'h0);
        drain();
        write_reg(CFG_K, 32'hFFFF_FFFF);
        write_reg(CFG_DAMP, 32'h01_0000);
        write_reg(CFG_T_START, 32'hFFFF_FFFF);
        send_item(REQ_START, 32'd0, 16'h0);
        for (int i = 0; i < 4; i++) send_item(1'b1, 32'h0100_0000, 16'hFFFE);
        drain();

        // Random phases over several settings.
        for (int p = 0; p < 10; p++) begin
            write_reg(CFG_K, (p % 3 == 0) ? 32'h0001_0000 : $urandom_range(1, 32'h0010_0000));
            write_reg(CFG_T_START, $urandom_range(32'h0000_1000, 32'h0020_0000));
            write_reg(CFG_T_MIN, $urandom_range(1, 32'h0000_2000));
            write_reg(CFG_T_RST, $urandom_range(0, 32'h0004_0000));
            write_reg(CFG_DAMP, $urandom_range(24'h01_0001, 24'h03_0000));
            write_reg(CFG_ITERS, $urandom_range(1, 12));
            run_phase(80);
            drain();
        end

        $display("Sent %0d items over directed cases and ten random configurations;",
                 items_sent);
        $display("%0d result items were checked.", sb.checked);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
`default_nettype wire
